### rtl/melody_note_sequencer_assert.svh
// Assertion macros shared by the melody note sequencer RTL.
`ifndef MELODY_NOTE_SEQUENCER_ASSERT_SVH
`define MELODY_NOTE_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define MNS_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`define MNS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define MNS_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define MNS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

### rtl/mns_pkg.sv
// Package with the types, codes and constants of the melody note sequencer.
package mns_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned ELAPSED_W = 18;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned LOOP_W   = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  localparam logic REG_SONG_LENGTH = 1'b0;
  localparam logic REG_LOOP_COUNT  = 1'b1;

  localparam logic [LEN_W-1:0]  SONG_LENGTH_RST = 7'd1;
  localparam logic [LOOP_W-1:0] LOOP_COUNT_RST  = 8'd1;

  typedef struct packed {
    logic [MS_W-1:0]   pause;
    logic [MS_W-1:0]   duration;
    logic [FREQ_W-1:0] freq;
  } note_t;

  typedef struct packed {
    logic              busy;
    logic [LOOP_W-1:0] loop_done;
    logic [SLOT_W-1:0] note;
    logic              sounding;
  } status_t;

endpackage

### rtl/mns_seq_core.sv
// Playback state of the melody note sequencer: timing, note advance and passes.
module mns_seq_core #(
  parameter int unsigned TABLE_DEPTH = mns_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_en,
  input  logic [mns_pkg::MODE_W-1:0]     mode,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mns_pkg::CFG_W-1:0]      cfg_wdata,
  input  mns_pkg::note_t                 cur_note,
  output logic [PTR_W-1:0]               rd_addr,
  output mns_pkg::status_t               status_nxt
);
  import mns_pkg::*;

  localparam int unsigned CNT_W = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

  logic [LEN_W-1:0]     song_length_r;
  logic [LOOP_W-1:0]    loop_count_r;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 restart_r, restart_nxt;
  logic [LOOP_W-1:0]    loop_r, loop_nxt, loop_inc;
  logic                 playing_r, playing_nxt;
  logic                 tone_r, tone_nxt;
  logic [CNT_W-1:0]     len_c, next_c;
  logic [MS_W:0]        total;
  logic [PTR_W+SLOT_W-1:0] ptr_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_length_r <= SONG_LENGTH_RST;
      loop_count_r  <= LOOP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SONG_LENGTH: song_length_r <= cfg_wdata[LEN_W-1:0];
        REG_LOOP_COUNT:  loop_count_r  <= cfg_wdata[LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_c = CNT_W'(song_length_r);
    if (len_c == '0) begin
      len_c = CNT_W'(1);
    end
    if (len_c > CNT_W'(TABLE_DEPTH)) begin
      len_c = CNT_W'(TABLE_DEPTH);
    end
  end

  assign next_c      = CNT_W'(ptr_r) + CNT_W'(1);
  assign total       = {1'b0, cur_note.duration} + {1'b0, cur_note.pause};
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + ELAPSED_W'(1);
  assign loop_inc    = loop_r + LOOP_W'(1);

  always_comb begin
    elapsed_nxt = elapsed_r;
    ptr_nxt     = ptr_r;
    restart_nxt = restart_r;
    loop_nxt    = loop_r;
    playing_nxt = playing_r;
    tone_nxt    = tone_r;
    if (item_en) begin
      case (mode)
        MODE_TICK: begin
          if (playing_r) begin
            if (restart_r) begin
              restart_nxt = 1'b0;
              ptr_nxt     = '0;
              elapsed_nxt = '0;
              tone_nxt    = 1'b1;
            end else begin
              elapsed_nxt = elapsed_inc;
              if (tone_r && (elapsed_inc >= ELAPSED_W'(cur_note.duration))) begin
                tone_nxt = 1'b0;
              end
              if (elapsed_inc >= ELAPSED_W'(total)) begin
                if (next_c < len_c) begin
                  ptr_nxt     = next_c[PTR_W-1:0];
                  elapsed_nxt = '0;
                  tone_nxt    = 1'b1;
                end else begin
                  loop_nxt = loop_inc;
                  tone_nxt = 1'b0;
                  if (loop_inc < loop_count_r) begin
                    restart_nxt = 1'b1;
                  end else begin
                    playing_nxt = 1'b0;
                  end
                end
              end
            end
          end
        end
        MODE_START: begin
          playing_nxt = 1'b1;
          restart_nxt = 1'b0;
          loop_nxt    = '0;
          ptr_nxt     = '0;
          elapsed_nxt = '0;
          tone_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      ptr_r     <= '0;
      restart_r <= 1'b0;
      loop_r    <= '0;
      playing_r <= 1'b0;
      tone_r    <= 1'b0;
    end else begin
      elapsed_r <= elapsed_nxt;
      ptr_r     <= ptr_nxt;
      restart_r <= restart_nxt;
      loop_r    <= loop_nxt;
      playing_r <= playing_nxt;
      tone_r    <= tone_nxt;
    end
  end

  assign ptr_wide = (PTR_W + SLOT_W)'(ptr_nxt);
  assign rd_addr  = ptr_nxt;

  always_comb begin
    status_nxt.busy      = playing_nxt;
    status_nxt.sounding  = playing_nxt & tone_nxt;
    status_nxt.note      = ptr_wide[SLOT_W-1:0];
    status_nxt.loop_done = loop_nxt;
  end

endmodule

### rtl/melody_note_sequencer.sv
// Top level of the melody note sequencer: stream ports, note table and result pipeline.
`include "melody_note_sequencer_assert.svh"

// Takes one beat per clock cycle unless in_tready is low, and returns exactly one result beat
// for each, through the status register and then the output register. A beat updates the
// playback state in the cycle it is accepted; the note table has one write and one registered
// read port, and the read address follows the next note pointer, so the current note's timing
// and frequency are ready in the cycle after the beat. A load that hits the note being read is
// forwarded into the read register. The table needs no clearing pass after reset, and a slot
// must be loaded before the song reaches it.
module melody_note_sequencer #(
  parameter int unsigned TABLE_DEPTH = mns_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // note_slot, note_frequency, note_duration, note_pause, then zero fill
  input  logic [mns_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic [mns_pkg::MODE_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sounding, tone_frequency, current_note, current_loop, busy_res
  output logic [mns_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mns_pkg::CFG_W-1:0]         cfg_wdata
);
  import mns_pkg::*;

  localparam int unsigned PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  note_t                     note_mem [TABLE_DEPTH];
  note_t                     note_rd_r;
  note_t                     wr_note;
  logic [PTR_W-1:0]          rd_addr;
  logic [PTR_W-1:0]          wr_addr;
  logic [PTR_W+SLOT_W-1:0]   slot_wide;
  logic [SLOT_W-1:0]         in_slot;
  logic                      in_fire;
  logic                      mem_we;
  logic                      s2_free;
  status_t                   status_nxt;
  status_t                   s1_r;
  logic                      s1_valid_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_r;
  logic [FREQ_W-1:0]         freq_sel;

  assign in_slot          = in_tdata[SLOT_W-1:0];
  assign wr_note.freq     = in_tdata[SLOT_W +: FREQ_W];
  assign wr_note.duration = in_tdata[SLOT_W+FREQ_W +: MS_W];
  assign wr_note.pause    = in_tdata[SLOT_W+FREQ_W+MS_W +: MS_W];

  assign s2_free   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_fire   = in_tvalid && in_tready;

  assign slot_wide = (PTR_W + SLOT_W)'(in_slot);
  assign wr_addr   = slot_wide[PTR_W-1:0];
  assign mem_we    = in_fire && (in_tuser == MODE_LOAD)
                     && (slot_wide < (PTR_W + SLOT_W)'(TABLE_DEPTH));

  mns_seq_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (in_fire),
    .mode       (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cur_note   (note_rd_r),
    .rd_addr    (rd_addr),
    .status_nxt (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[wr_addr] <= wr_note;
    end
    if (mem_we && (wr_addr == rd_addr)) begin
      note_rd_r <= wr_note;
    end else begin
      note_rd_r <= note_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= status_nxt;
    end
  end

  assign freq_sel = s1_r.busy ? note_rd_r.freq : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      out_r <= {s1_r.busy, s1_r.loop_done, s1_r.note, freq_sel, s1_r.sounding};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `MNS_ASSERT_IMPLY(a_sound_needs_busy, clk, rst_n, out_valid_r, !out_r[0] || out_r[OUT_DATA_W-1], "sounding result while not busy")
  `MNS_ASSERT_IMPLY(a_hold_when_full, clk, rst_n, s1_valid_r && !s2_free, !in_tready, "input taken while both stages are full")
  `MNS_ASSERT_IMPLY(a_ptr_in_table, clk, rst_n, 1'b1, (PTR_W + 1)'(rd_addr) < (PTR_W + 1)'(TABLE_DEPTH), "note pointer beyond the table")
  `MNS_ASSERT_NEXT(a_start_note0, clk, rst_n, in_fire && (in_tuser == MODE_START), s1_valid_r && s1_r.busy && s1_r.sounding && (s1_r.note == '0), "start beat did not begin the first note")

endmodule
